// ===== src/uv_sphere_mesh_generator_macros.svh =====
// Assertion shorthands for the sphere generator; each expects clk and arst_n in scope.
`ifndef UV_SPHERE_MESH_GENERATOR_MACROS_SVH
`define UV_SPHERE_MESH_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define UVS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define UVS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/uvs_pkg.sv =====
`timescale 1ns / 1ps
package uvs_pkg;

	localparam int MAX_STACKS  = 256;
	localparam int MAX_SECTORS = 256;
	localparam int FRAC_BITS   = 12;

	localparam logic [8:0]  RST_STACKS  = 9'd16;
	localparam logic [8:0]  RST_SECTORS = 9'd32;
	localparam logic [15:0] RST_RADIUS  = 16'(1 << FRAC_BITS);

	// register indexes
	localparam logic [1:0] REG_STACKS  = 2'd0;
	localparam logic [1:0] REG_SECTORS = 2'd1;
	localparam logic [1:0] REG_RADIUS  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_TRI    = 2'd1;
	localparam logic [1:0] KIND_RANGE  = 2'd2;

	// quadrants of a phase
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

	// phase divider: DIV_STAGES * DIV_STEPS numerator bits
	localparam int DIV_STEPS  = 7;
	localparam int DIV_STAGES = 6;
	localparam int NUM_W      = DIV_STEPS * DIV_STAGES;

	// series: three stages per term
	localparam int HZ_TERMS  = 7;
	localparam int HZ_STAGES = 3 * HZ_TERMS;

	localparam int PIPE_DEPTH = 1 + DIV_STAGES + 2 + HZ_STAGES + 6;

	typedef struct packed {
		logic [8:0]  stacks;
		logic [8:0]  sectors;
		logic [15:0] radius;
	} geom_t;

	typedef struct packed {
		logic        err;
		logic        has_a;
		logic        has_b;
		logic [16:0] k1;
		logic [16:0] k2;
	} ctl_t;

	typedef struct packed {
		logic signed [16:0] pos_x;
		logic signed [16:0] pos_y;
		logic signed [16:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
	} vtx_t;

	typedef enum logic [1:0] {
		PH_VERT,
		PH_TRI_A,
		PH_TRI_B
	} phase_t;

	// arithmetic shift right, rounding half away from zero
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int sh);
		logic signed [63:0] h;
		logic signed [63:0] m;
		h = 64'sd1 <<< (sh - 1);
		if (v < 0) begin
			m = -v;
			rnd_shr = -((m + h) >>> sh);
		end else begin
			rnd_shr = (v + h) >>> sh;
		end
	endfunction

endpackage

// ===== src/uvs_pipe.sv =====
`timescale 1ns / 1ps
module uvs_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  logic [8:0]     stack_index,
	input  logic [8:0]     sector_index,
	input  uvs_pkg::geom_t geom,
	output logic           out_valid,
	output uvs_pkg::ctl_t  out_ctl,
	output uvs_pkg::vtx_t  out_vtx
);

	localparam int DS    = uvs_pkg::DIV_STAGES;
	localparam int HZ    = uvs_pkg::HZ_STAGES;
	localparam int DEPTH = uvs_pkg::PIPE_DEPTH;
	localparam int NW    = uvs_pkg::NUM_W;

	logic [DEPTH-1:0] vld_s;
	uvs_pkg::ctl_t    ctl_s [DEPTH];
	uvs_pkg::ctl_t    ctl_in;
	logic             on_cell;
	logic [18:0]      k1_w;
	logic [NW-1:0]    num_in [2];

	// entry: grid checks, vertex indices, divider numerators
	always_comb begin
		ctl_in.err   = (stack_index > geom.stacks) || (sector_index > geom.sectors);
		on_cell      = (stack_index < geom.stacks) && (sector_index < geom.sectors);
		ctl_in.has_a = on_cell && (stack_index != 9'd0);
		ctl_in.has_b = on_cell && (stack_index != geom.stacks - 9'd1);
		k1_w         = 19'(stack_index) * (19'(geom.sectors) + 19'd1) + 19'(sector_index);
		ctl_in.k1    = k1_w[16:0];
		ctl_in.k2    = 17'(k1_w + 19'(geom.sectors) + 19'd1);
		num_in[0]    = NW'({stack_index, 31'd0}) + NW'(geom.stacks[8:1]);
		num_in[1]    = NW'({sector_index, 32'd0}) + NW'(geom.sectors[8:1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[DEPTH-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s[0] <= ctl_in;
			for (int n = 1; n < DEPTH; n++) begin
				ctl_s[n] <= ctl_s[n-1];
			end
		end
	end

	// w = 0 latitude (theta), w = 1 longitude
	logic [NW-1:0] dnum_s [2][DS+1];
	logic [7:0]    drem_s [2][DS+1];
	logic [31:0]   dquo_s [2][DS+1];

	logic [30:0] hz_x_s    [2][HZ+1];
	logic [31:0] hz_x2_s   [2][HZ+1];
	logic [1:0]  hz_quad_s [2][HZ+1];
	logic [30:0] hz_ts_s   [2][HZ+1];
	logic [30:0] hz_tc_s   [2][HZ+1];
	logic [31:0] hz_ps_s   [2][HZ+1];
	logic [31:0] hz_pc_s   [2][HZ+1];
	logic [31:0] hz_qs_s   [2][HZ+1];
	logic [31:0] hz_qc_s   [2][HZ+1];

	logic signed [31:0] sn_s31 [2];
	logic signed [31:0] cs_s31 [2];

	for (genvar w = 0; w < 2; w++) begin : g_w
		logic [8:0]  dvs;
		logic [1:0]  quad_s7;
		logic [30:0] x_s7;
		logic [30:0] s_s30;
		logic [30:0] tc_s30;
		logic [1:0]  quad_s30;

		assign dvs = (w == 0) ? geom.stacks : geom.sectors;

		always_ff @(posedge clk) begin
			if (adv) begin
				dnum_s[w][0] <= num_in[w];
				drem_s[w][0] <= '0;
				dquo_s[w][0] <= '0;
			end
		end

		// restoring division, DIV_STEPS quotient bits a stage
		for (genvar s = 1; s <= DS; s++) begin : g_div
			logic [NW-1:0] n_c;
			logic [7:0]    r_c;
			logic [31:0]   q_c;

			always_comb begin
				logic [8:0] t;
				n_c = dnum_s[w][s-1];
				r_c = drem_s[w][s-1];
				q_c = dquo_s[w][s-1];
				for (int b = 0; b < uvs_pkg::DIV_STEPS; b++) begin
					t   = {r_c, n_c[NW-1]};
					n_c = {n_c[NW-2:0], 1'b0};
					if (t >= dvs) begin
						t   = t - dvs;
						q_c = {q_c[30:0], 1'b1};
					end else begin
						q_c = {q_c[30:0], 1'b0};
					end
					r_c = t[7:0];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					dnum_s[w][s] <= n_c;
					drem_s[w][s] <= r_c;
					dquo_s[w][s] <= q_c;
				end
			end
		end

		// phase remainder to radians, then its square
		always_ff @(posedge clk) begin
			if (adv) begin
				quad_s7 <= dquo_s[w][DS][31:30];
				x_s7    <= 31'((64'(dquo_s[w][DS][29:0]) * 64'(uvs_pkg::HALF_PI_Q30)) >> 30);
				hz_quad_s[w][0] <= quad_s7;
				hz_x_s[w][0]    <= x_s7;
				hz_x2_s[w][0]   <= 32'((64'(x_s7) * 64'(x_s7)) >> 30);
				hz_ts_s[w][0]   <= uvs_pkg::Q30_ONE;
				hz_tc_s[w][0]   <= uvs_pkg::Q30_ONE;
				hz_ps_s[w][0]   <= '0;
				hz_pc_s[w][0]   <= '0;
				hz_qs_s[w][0]   <= '0;
				hz_qc_s[w][0]   <= '0;
			end
		end

		// Horner terms: multiply, reciprocal multiply, correct and subtract
		for (genvar h = 1; h <= HZ; h++) begin : g_hz
			localparam int K   = uvs_pkg::HZ_TERMS - (h - 1) / 3;
			localparam int SUB = (h - 1) % 3;
			localparam int CS  = 2 * K * (2 * K + 1);
			localparam int CC  = (2 * K - 1) * (2 * K);
			localparam logic [31:0] MS = 32'((64'd1 << 32) / CS);
			localparam logic [31:0] MC = 32'((64'd1 << 32) / CC);

			logic [31:0] ps_c, pc_c, qs_c, qc_c;
			logic [30:0] ts_c, tc_c;

			if (SUB == 0) begin : g_mul
				always_comb begin
					ps_c = 32'((64'(hz_x2_s[w][h-1]) * 64'(hz_ts_s[w][h-1])) >> 30);
					pc_c = 32'((64'(hz_x2_s[w][h-1]) * 64'(hz_tc_s[w][h-1])) >> 30);
					qs_c = hz_qs_s[w][h-1];
					qc_c = hz_qc_s[w][h-1];
					ts_c = hz_ts_s[w][h-1];
					tc_c = hz_tc_s[w][h-1];
				end
			end else if (SUB == 1) begin : g_rcp
				always_comb begin
					ps_c = hz_ps_s[w][h-1];
					pc_c = hz_pc_s[w][h-1];
					qs_c = 32'((64'(hz_ps_s[w][h-1]) * 64'(MS)) >> 32);
					qc_c = 32'((64'(hz_pc_s[w][h-1]) * 64'(MC)) >> 32);
					ts_c = hz_ts_s[w][h-1];
					tc_c = hz_tc_s[w][h-1];
				end
			end else begin : g_fix
				always_comb begin
					logic [32:0] rs, rc, ds, dc;
					rs = 33'(hz_ps_s[w][h-1]) - 33'(hz_qs_s[w][h-1]) * 33'(CS);
					rc = 33'(hz_pc_s[w][h-1]) - 33'(hz_qc_s[w][h-1]) * 33'(CC);
					ds = 33'(hz_qs_s[w][h-1]) + ((rs >= 33'(CS)) ? 33'd1 : 33'd0);
					dc = 33'(hz_qc_s[w][h-1]) + ((rc >= 33'(CC)) ? 33'd1 : 33'd0);
					ps_c = hz_ps_s[w][h-1];
					pc_c = hz_pc_s[w][h-1];
					qs_c = hz_qs_s[w][h-1];
					qc_c = hz_qc_s[w][h-1];
					ts_c = (ds > 33'(uvs_pkg::Q30_ONE)) ? 31'd0
						: 31'(33'(uvs_pkg::Q30_ONE) - ds);
					tc_c = (dc > 33'(uvs_pkg::Q30_ONE)) ? 31'd0
						: 31'(33'(uvs_pkg::Q30_ONE) - dc);
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					hz_x_s[w][h]    <= hz_x_s[w][h-1];
					hz_x2_s[w][h]   <= hz_x2_s[w][h-1];
					hz_quad_s[w][h] <= hz_quad_s[w][h-1];
					hz_ps_s[w][h]   <= ps_c;
					hz_pc_s[w][h]   <= pc_c;
					hz_qs_s[w][h]   <= qs_c;
					hz_qc_s[w][h]   <= qc_c;
					hz_ts_s[w][h]   <= ts_c;
					hz_tc_s[w][h]   <= tc_c;
				end
			end
		end

		// sine from the series, then quadrant symmetry
		always_ff @(posedge clk) begin
			logic [30:0] sv;
			if (adv) begin
				sv = 31'((64'(hz_x_s[w][HZ]) * 64'(hz_ts_s[w][HZ])) >> 30);
				s_s30    <= (sv > uvs_pkg::Q30_ONE) ? uvs_pkg::Q30_ONE : sv;
				tc_s30   <= hz_tc_s[w][HZ];
				quad_s30 <= hz_quad_s[w][HZ];
				case (quad_s30)
					uvs_pkg::QUAD_0: begin
						sn_s31[w] <= $signed(32'(s_s30));
						cs_s31[w] <= $signed(32'(tc_s30));
					end
					uvs_pkg::QUAD_1: begin
						sn_s31[w] <= $signed(32'(tc_s30));
						cs_s31[w] <= -$signed(32'(s_s30));
					end
					uvs_pkg::QUAD_2: begin
						sn_s31[w] <= -$signed(32'(s_s30));
						cs_s31[w] <= -$signed(32'(tc_s30));
					end
					default: begin
						sn_s31[w] <= -$signed(32'(tc_s30));
						cs_s31[w] <= $signed(32'(s_s30));
					end
				endcase
			end
		end
	end

	// unit vector, normal and scaled position
	logic signed [63:0] px_s32, py_s32;
	logic signed [31:0] uz_s32;
	logic signed [31:0] ux_s33, uy_s33, uz_s33;
	logic signed [63:0] rx_s34, ry_s34, rz_s34;
	logic signed [15:0] nx_s34, ny_s34, nz_s34;
	uvs_pkg::vtx_t      vtx_s35;
	logic signed [63:0] rad_w;

	assign rad_w = $signed({48'd0, geom.radius});

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s32 <= 64'(sn_s31[0]) * 64'(cs_s31[1]);
			py_s32 <= 64'(sn_s31[0]) * 64'(sn_s31[1]);
			uz_s32 <= cs_s31[0];

			ux_s33 <= 32'(uvs_pkg::rnd_shr(px_s32, 30));
			uy_s33 <= 32'(uvs_pkg::rnd_shr(py_s32, 30));
			uz_s33 <= uz_s32;

			rx_s34 <= rad_w * 64'(ux_s33);
			ry_s34 <= rad_w * 64'(uy_s33);
			rz_s34 <= rad_w * 64'(uz_s33);
			nx_s34 <= 16'(uvs_pkg::rnd_shr(64'(ux_s33), 16));
			ny_s34 <= 16'(uvs_pkg::rnd_shr(64'(uy_s33), 16));
			nz_s34 <= 16'(uvs_pkg::rnd_shr(64'(uz_s33), 16));

			vtx_s35.pos_x  <= 17'(uvs_pkg::rnd_shr(rx_s34, 30));
			vtx_s35.pos_y  <= 17'(uvs_pkg::rnd_shr(ry_s34, 30));
			vtx_s35.pos_z  <= 17'(uvs_pkg::rnd_shr(rz_s34, 30));
			vtx_s35.norm_x <= nx_s34;
			vtx_s35.norm_y <= ny_s34;
			vtx_s35.norm_z <= nz_s34;
		end
	end

	assign out_valid = vld_s[DEPTH-1];
	assign out_ctl   = ctl_s[DEPTH-1];
	assign out_vtx   = vtx_s35;

endmodule

// ===== src/uv_sphere_mesh_generator.sv =====
`timescale 1ns / 1ps
// UV sphere tessellator. Each input transfer names a grid point (stack i, sector j); the
// block returns that point's vertex (Q4.12 position, Q1.14 unit normal) and then, for a
// grid cell, the one or two index triangles that start there, each with last on the final
// result of the point. Points off the grid return a single out-of-range result. Results
// leave one per cycle on one port while out_stall is low; a point gives one result when it
// is off the grid or on the last row or column, two at a cell of either cap row and three
// at an inner cell. The output port is the limit; the arithmetic pipeline behind it takes
// a new point every cycle while the result holder can take its output. A point passes the
// divider, sine series and scaling stages, then the result holder, on its way to the output.
// Write stack_count, sector_count and sphere_radius only while the block is empty.
module uv_sphere_mesh_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [8:0]         stack_index,
	input  logic [8:0]         sector_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [16:0]        corner_a,
	output logic [16:0]        corner_b,
	output logic [16:0]        corner_c,
	output logic               last
);

	`include "uv_sphere_mesh_generator_macros.svh"

	logic [8:0]  stack_count_q;
	logic [8:0]  sector_count_q;
	logic [15:0] sphere_radius_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_count_q   <= uvs_pkg::RST_STACKS;
			sector_count_q  <= uvs_pkg::RST_SECTORS;
			sphere_radius_q <= uvs_pkg::RST_RADIUS;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				uvs_pkg::REG_STACKS:  stack_count_q   <= cfg_data[8:0];
				uvs_pkg::REG_SECTORS: sector_count_q  <= cfg_data[8:0];
				uvs_pkg::REG_RADIUS:  sphere_radius_q <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// clamp the grid to what the hardware supports
	uvs_pkg::geom_t geom;

	always_comb begin
		if (stack_count_q < 9'd2) begin
			geom.stacks = 9'd2;
		end else if (10'(stack_count_q) > 10'(uvs_pkg::MAX_STACKS)) begin
			geom.stacks = 9'(uvs_pkg::MAX_STACKS);
		end else begin
			geom.stacks = stack_count_q;
		end
		if (sector_count_q < 9'd3) begin
			geom.sectors = 9'd3;
		end else if (10'(sector_count_q) > 10'(uvs_pkg::MAX_SECTORS)) begin
			geom.sectors = 9'(uvs_pkg::MAX_SECTORS);
		end else begin
			geom.sectors = sector_count_q;
		end
		geom.radius = sphere_radius_q;
	end

	// arithmetic pipeline; it moves only when the result holder can take its output
	logic           adv;
	logic           pipe_valid;
	uvs_pkg::ctl_t  pipe_ctl;
	uvs_pkg::vtx_t  pipe_vtx;

	uvs_pipe u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (in_valid),
		.stack_index  (stack_index),
		.sector_index (sector_index),
		.geom         (geom),
		.out_valid    (pipe_valid),
		.out_ctl      (pipe_ctl),
		.out_vtx      (pipe_vtx)
	);

	// result holder: one finished point, played out as vertex then triangles, or as one out-of-range result
	logic             hold_valid_q;
	uvs_pkg::ctl_t    hold_ctl_q;
	uvs_pkg::vtx_t    hold_vtx_q;
	uvs_pkg::phase_t  phase_q, phase_d;
	logic             out_xfer;
	logic             is_last;

	assign out_xfer = out_valid && !out_stall;
	assign adv      = !hold_valid_q || (out_xfer && is_last);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			phase_q      <= uvs_pkg::PH_VERT;
		end else if (adv) begin
			hold_valid_q <= pipe_valid;
			phase_q      <= uvs_pkg::PH_VERT;
		end else if (out_xfer) begin
			phase_q      <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hold_ctl_q <= pipe_ctl;
			hold_vtx_q <= pipe_vtx;
		end
	end

	// next result of the held point, and whether the current one ends it
	always_comb begin
		phase_d = phase_q;
		is_last = 1'b1;
		unique case (phase_q)
			uvs_pkg::PH_VERT: begin
				if (!hold_ctl_q.err && hold_ctl_q.has_a) begin
					phase_d = uvs_pkg::PH_TRI_A;
					is_last = 1'b0;
				end else if (!hold_ctl_q.err && hold_ctl_q.has_b) begin
					phase_d = uvs_pkg::PH_TRI_B;
					is_last = 1'b0;
				end
			end
			uvs_pkg::PH_TRI_A: begin
				if (hold_ctl_q.has_b) begin
					phase_d = uvs_pkg::PH_TRI_B;
					is_last = 1'b0;
				end
			end
			uvs_pkg::PH_TRI_B: begin
				is_last = 1'b1;
			end
			default: begin
				is_last = 1'b1;
			end
		endcase
	end

	// result fields; unused fields read as zero
	always_comb begin
		kind     = uvs_pkg::KIND_VERTEX;
		pos_x    = '0;
		pos_y    = '0;
		pos_z    = '0;
		norm_x   = '0;
		norm_y   = '0;
		norm_z   = '0;
		corner_a = '0;
		corner_b = '0;
		corner_c = '0;
		if (hold_ctl_q.err) begin
			kind = uvs_pkg::KIND_RANGE;
		end else if (phase_q == uvs_pkg::PH_VERT) begin
			pos_x  = hold_vtx_q.pos_x;
			pos_y  = hold_vtx_q.pos_y;
			pos_z  = hold_vtx_q.pos_z;
			norm_x = hold_vtx_q.norm_x;
			norm_y = hold_vtx_q.norm_y;
			norm_z = hold_vtx_q.norm_z;
		end else if (phase_q == uvs_pkg::PH_TRI_A) begin
			kind     = uvs_pkg::KIND_TRI;
			corner_a = hold_ctl_q.k1;
			corner_b = hold_ctl_q.k2;
			corner_c = hold_ctl_q.k1 + 17'd1;
		end else begin
			kind     = uvs_pkg::KIND_TRI;
			corner_a = hold_ctl_q.k1 + 17'd1;
			corner_b = hold_ctl_q.k2;
			corner_c = hold_ctl_q.k2 + 17'd1;
		end
	end

	assign out_valid = hold_valid_q;
	assign last      = is_last;

	`UVS_ASSERT_IMPL(a_range_single, out_valid && kind == uvs_pkg::KIND_RANGE, last, "out-of-range point gave more than one result")
	`UVS_ASSERT_NEXT(a_point_continues, out_xfer && !last, out_valid && kind == uvs_pkg::KIND_TRI, "point ended before its triangles")
	`UVS_ASSERT_IMPL(a_tri_corner, out_valid && kind == uvs_pkg::KIND_TRI, corner_c == corner_a + 17'd1 || corner_c == corner_b + 17'd1, "triangle corners inconsistent")
	`UVS_ASSERT_IMPL(a_input_held, hold_valid_q && !out_xfer, in_stall, "input taken while result still pending")

endmodule
